// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions of the SHA-256 block hasher
// Holds the round constants, the initial hash value and the SHA-256 bit
// mixing functions used by the schedule window and the round datapath.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int WORD_W   = 32;
    localparam int NUM_VARS = 8;
    localparam int WIN_DEPTH = 16;
    localparam int ROUND_W  = 6;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_VARS-1:0] vars_t;

    // Control from the sequencer to the schedule window.
    typedef struct packed {
        logic load;   // shift in a message word
        logic step;   // shift in a freshly expanded schedule word
    } sched_ctrl_t;

    localparam vars_t INIT_VALUE = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t rotr(input word_t v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    function automatic word_t small_sig0(input word_t v);
        return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t small_sig1(input word_t v);
        return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic word_t big_sig0(input word_t v);
        return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic word_t big_sig1(input word_t v);
        return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic word_t round_k(input logic [ROUND_W-1:0] r);
        word_t k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h428a2f98;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/sha_sched.sv =====
// ----------------------------------------------------------------------------
// sha_sched: sixteen-word message schedule window
// A shift line of sixteen words. Message words shift in during loading; during
// the rounds each cycle shifts in the next expanded schedule word.
// ----------------------------------------------------------------------------
module sha_sched
    import sha_pkg::*;
(
    input  logic        clk,
    input  sched_ctrl_t ctrl,
    input  word_t       msg_word,
    output word_t       w_cur
);

    word_t win_reg [WIN_DEPTH];
    word_t win_next;
    word_t expand;

    // Tap 0 holds the oldest word, which is the word used by the current round.
    assign expand = win_reg[0] + small_sig0(win_reg[1]) + win_reg[9]
                  + small_sig1(win_reg[14]);
    assign win_next = ctrl.load ? msg_word : expand;
    assign w_cur = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctrl.load || ctrl.step)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_DEPTH-1] <= win_next;
        end
    end

endmodule

// ===== hw/rtl/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round: one SHA-256 compression round
// Combinational round function shared by all 64 rounds of a block.
// ----------------------------------------------------------------------------
module sha_round
    import sha_pkg::*;
(
    input  vars_t cur,
    input  word_t w,
    input  word_t k,
    output vars_t nxt
);

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    // Word order: index 0 is a, index 7 is h.
    assign ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    assign maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    assign t1  = cur[7] + big_sig1(cur[4]) + ch + k + w;
    assign t2  = big_sig0(cur[0]) + maj;

    always_comb
    begin
        nxt[7] = cur[6];
        nxt[6] = cur[5];
        nxt[5] = cur[4];
        nxt[4] = cur[3] + t1;
        nxt[3] = cur[2];
        nxt[2] = cur[1];
        nxt[1] = cur[0];
        nxt[0] = t1 + t2;
    end

endmodule

// ===== hw/rtl/sha256_block_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_block_hasher: iterative SHA-256 compression of a padded message
// Collects sixteen message words per block, runs the 64 rounds on a shared
// round unit one per cycle, folds the result into the chaining value and
// streams the eight digest words after the final block.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Beat contents
// s_axis    in         tdata = msg_word[31:0]; tuser = {final_block, new_message}
// m_axis    out        tdata = digest_word[31:0]; tlast = last_word
//
// A message word is taken on each handshake while the block is loading. The
// sixteenth word of a block starts the compression: the 64 rounds on the
// single round unit, then an add step that adds the working variables into
// the chaining value; no word is taken meanwhile. After a final block the
// digest goes to an eight-word output buffer that drains one beat per cycle
// while the receiver is ready, even as the next block loads; a later final
// block waits in the add state until the buffer has drained. Reset loads the
// SHA-256 initial value into the chaining value and clears all control state.
// ----------------------------------------------------------------------------
module sha256_block_hasher
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] msg_word
    input  logic [1:0]  s_tuser,    // [0] new_message, [1] final_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic        m_tlast
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_ADD   = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [3:0]         word_cnt_reg, word_cnt_next;
    logic [ROUND_W-1:0] round_cnt_reg, round_cnt_next;
    logic               final_reg, final_next;
    vars_t              chain_reg, chain_next;
    vars_t              work_reg, work_next;
    logic [3:0]         out_cnt_reg, out_cnt_next;
    word_t              obuf_reg [NUM_VARS];

    logic               in_beat;
    logic               out_beat;
    logic               new_message;
    logic               final_block;
    logic               obuf_load;
    sched_ctrl_t        sched_ctrl;
    word_t              w_cur;
    vars_t              round_out;
    vars_t              chain_sum;

    assign new_message = s_tuser[0];
    assign final_block = s_tuser[1];

    assign s_tready = (state_reg == ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = (out_cnt_reg != 4'd0);
    assign out_beat = m_tvalid && m_tready;
    assign m_tdata  = obuf_reg[0];
    assign m_tlast  = (out_cnt_reg == 4'd1);

    assign sched_ctrl.load = in_beat;
    assign sched_ctrl.step = (state_reg == ST_ROUND);

    sha_sched u_sched (
        .clk      (clk),
        .ctrl     (sched_ctrl),
        .msg_word (s_tdata),
        .w_cur    (w_cur)
    );

    sha_round u_round (
        .cur (work_reg),
        .w   (w_cur),
        .k   (round_k(round_cnt_reg)),
        .nxt (round_out)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_VARS; i++)
        begin
            chain_sum[i] = chain_reg[i] + work_reg[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        round_cnt_next = round_cnt_reg;
        final_next     = final_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        obuf_load      = 1'b0;
        out_cnt_next   = out_beat ? out_cnt_reg - 4'd1 : out_cnt_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    // A new message drops any partial block and restarts the chain.
                    if (new_message)
                    begin
                        chain_next    = INIT_VALUE;
                        word_cnt_next = 4'd1;
                    end
                    else
                    begin
                        word_cnt_next = word_cnt_reg + 4'd1;
                        if (word_cnt_reg == 4'd15)
                        begin
                            final_next     = final_block;
                            work_next      = chain_reg;
                            round_cnt_next = '0;
                            state_next     = ST_ROUND;
                        end
                    end
                end
            end
            ST_ROUND:
            begin
                work_next      = round_out;
                round_cnt_next = round_cnt_reg + 1'b1;
                if (round_cnt_reg == {ROUND_W{1'b1}})
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!final_reg || (out_cnt_reg == 4'd0))
                begin
                    chain_next = chain_sum;
                    state_next = ST_LOAD;
                    if (final_reg)
                    begin
                        obuf_load    = 1'b1;
                        out_cnt_next = 4'(NUM_VARS);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            final_reg     <= 1'b0;
            chain_reg     <= INIT_VALUE;
            work_reg      <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            round_cnt_reg <= round_cnt_next;
            final_reg     <= final_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    // Output buffer: loaded with H0..H7, shifts toward tap 0 on each beat.
    always_ff @(posedge clk)
    begin
        if (obuf_load)
        begin
            for (int i = 0; i < NUM_VARS; i++)
            begin
                obuf_reg[i] <= chain_sum[i];
            end
        end
        else if (out_beat)
        begin
            for (int i = 0; i < NUM_VARS - 1; i++)
            begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
            obuf_reg[NUM_VARS-1] <= obuf_reg[NUM_VARS-1];
        end
    end

endmodule

// ===== dv/sha256_block_hasher_test.sv =====
// ----------------------------------------------------------------------------
// sha256_block_hasher_test: self-checking bench for the SHA-256 block hasher
// Streams padded messages into the hasher and keeps a behavioral SHA-256
// model in step with every accepted word. Each digest beat is checked
// against the oldest expected digest word. Both stream sides idle at random,
// and one phase holds the digest side off long enough to back up the input.
// ----------------------------------------------------------------------------
module sha256_block_hasher_test;

    typedef sha_pkg::word_t word_t;

    // One expected digest beat: the word itself and its end-of-digest mark.
    typedef struct {
        word_t digest_word;
        bit    last_word;
    } digest_beat_t;

    // No-progress limit. The longest legal quiet stretch is the forced
    // receiver hold-off plus one compression.
    localparam int QUIET_LIMIT = 4000;
    // Cycles watched after the last expected beat, for stray output beats.
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_CYCLES = 600;

    localparam word_t SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;      // [31:0] msg_word
    logic [1:0]  s_tuser = '0;      // [0] new_message, [1] final_block
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] digest_word
    logic        m_tlast;           // last_word

    // Model state: chaining value, schedule window and position in block.
    word_t       chain_h [8];
    word_t       sched_w [16];
    logic [3:0]  word_pos;

    digest_beat_t digest_q [$];

    int error_count    = 0;
    int words_sent     = 0;
    int messages_sent  = 0;
    int blocks_hashed  = 0;
    int digests_seen   = 0;
    int quiet_cycles   = 0;
    bit tx_burst       = 1'b0;      // sender offers back-to-back beats
    int rx_hold_req    = 0;         // cycles of forced receiver hold-off

    sha256_block_hasher dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral SHA-256
    // ------------------------------------------------------------------------

    function automatic word_t ror(input word_t v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // Schedule mixer: two rotations and a plain shift.
    function automatic word_t mix_shift(input word_t v, input int a, input int b,
                                        input int sh);
        return ror(v, a) ^ ror(v, b) ^ (v >> sh);
    endfunction

    // Round mixer: three rotations.
    function automatic word_t mix_rot(input word_t v, input int a, input int b,
                                      input int c);
        return ror(v, a) ^ ror(v, b) ^ ror(v, c);
    endfunction

    // Runs the 64 rounds over the window and folds them into the chain.
    // The window is expanded in place, sixteen words deep.
    task automatic compress_block();
        word_t v [8];
        word_t wr;
        word_t t1;
        word_t t2;
        int    r;
        for (r = 0; r < 8; r++)
            v[r] = chain_h[r];
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
                wr = sched_w[r];
            else
            begin
                wr = sched_w[r % 16] + mix_shift(sched_w[(r + 1) % 16], 7, 18, 3)
                   + sched_w[(r + 9) % 16] + mix_shift(sched_w[(r + 14) % 16], 17, 19, 10);
                sched_w[r % 16] = wr;
            end
            t1 = v[7] + mix_rot(v[4], 6, 11, 25) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
               + SHA_K[r] + wr;
            t2 = mix_rot(v[0], 2, 13, 22) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++)
            chain_h[r] = chain_h[r] + v[r];
        blocks_hashed++;
    endtask

    // Takes one accepted message word. A new-message word drops any partial
    // block and reloads the initial value; the final flag only counts on the
    // sixteenth word of a block, which then yields the eight digest words.
    task automatic hash_absorb_word(input word_t w, input bit fresh, input bit fin);
        digest_beat_t beat;
        int           i;
        if (fresh)
        begin
            for (i = 0; i < 8; i++)
                chain_h[i] = SHA_IV[i];
            word_pos = '0;
        end
        sched_w[word_pos] = w;
        word_pos = word_pos + 4'd1;
        if (word_pos == 4'd0)
        begin
            compress_block();
            if (fin)
            begin
                for (i = 0; i < 8; i++)
                begin
                    beat.digest_word = chain_h[i];
                    beat.last_word   = (i == 7);
                    digest_q.push_back(beat);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_burst || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Message words lean toward the all-zero and all-one extremes.
    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    // Offers one beat, waits for its handshake and feeds the model.
    task automatic send_word(input word_t w, input bit fresh, input bit fin);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= {fin, fresh};
        do
            @(posedge clk);
        while (!s_tready);
        hash_absorb_word(w, fresh, fin);
        words_sent++;
    endtask

    // Sends a whole padded message of the given number of blocks. The final
    // flag is noise on all but the sixteenth word of each block, where it is
    // set only on the last block, and only if the digest is wanted.
    task automatic send_message(input int blocks, input bit fresh, input bit emit);
        int b;
        int i;
        bit fin;
        for (b = 0; b < blocks; b++)
        begin
            for (i = 0; i < 16; i++)
            begin
                if (i == 15)
                    fin = emit && (b == blocks - 1);
                else
                    fin = $urandom_range(0, 1);
                send_word(pick_word(), fresh && b == 0 && i == 0, fin);
            end
        end
        messages_sent++;
    endtask

    // A broken block: up to fifteen words with random flags, too few to fill a block alone.
    task automatic send_fragment();
        int n;
        int i;
        n = $urandom_range(1, 15);
        for (i = 0; i < n; i++)
            send_word(pick_word(), $urandom_range(0, 3) == 0, $urandom_range(0, 1));
    endtask

    // The sender goes idle and waits until every expected digest beat is out.
    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (digest_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extreme words with the final flag set early, then a restart in
    // mid-block that drops them, followed by the one-block "abc" message.
    task automatic test_edge_words();
        int i;
        send_word(32'hffff_ffff, 1'b1, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b1);
        send_word(32'hffff_ffff, 1'b0, 1'b0);
        send_word(32'h6162_6380, 1'b1, 1'b1);
        for (i = 1; i < 15; i++)
            send_word('0, 1'b0, 1'b1);
        send_word(32'h0000_0018, 1'b0, 1'b1);
    endtask

    // Mostly well-formed messages of one to three blocks. Some continue from
    // the previous chaining value, some end without a digest, and some
    // broken fragments force a restart.
    task automatic test_chained_messages(input int n_words);
        int stop_at;
        int kind;
        int blocks;
        bit need_fresh;
        stop_at    = words_sent + n_words;
        need_fresh = 1'b0;
        while (words_sent < stop_at)
        begin
            tx_burst = ($urandom_range(0, 3) == 0);
            kind     = $urandom_range(0, 9);
            blocks   = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 3);
            if (kind == 0)
            begin
                send_fragment();
                need_fresh = 1'b1;
            end
            else if (kind == 1 && !need_fresh)
                send_message(blocks, 1'b0, 1'b1);
            else if (kind == 2)
            begin
                send_message(blocks, 1'b1, 1'b0);
                need_fresh = 1'b0;
            end
            else
            begin
                send_message(blocks, 1'b1, 1'b1);
                need_fresh = 1'b0;
            end
        end
        tx_burst = 1'b0;
    endtask

    // The receiver stops for a long stretch while the sender keeps streaming
    // final blocks; the output buffer fills and the input has to stall.
    task automatic test_output_stall();
        int i;
        rx_hold_req = HOLD_CYCLES;
        tx_burst    = 1'b1;
        for (i = 0; i < 3; i++)
            send_message(1, 1'b1, 1'b1);
        tx_burst = 1'b0;
    endtask

    // The sender stops until every digest is out, then chains one block on
    // the last digest and sends a fresh two-block message.
    task automatic test_drain_pause();
        wait_for_digests();
        send_message(1, 1'b0, 1'b1);
        send_message(2, 1'b1, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready with short and long stalls, steady stretches,
    // and forced hold-offs on request.
    // ------------------------------------------------------------------------
    initial
    begin : rx_side
        int hold_left;
        int stall_left;
        int mode_left;
        int r;
        bit steady;
        hold_left  = 0;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req != 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (mode_left == 0)
            begin
                steady    = ($urandom_range(0, 2) == 0);
                mode_left = $urandom_range(30, 120);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (steady)
                m_tready <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Digest checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %08h, expected %08h (digest beat %0d)",
                 what, got, want, digests_seen);
        error_count++;
    endtask

    always @(posedge clk)
    begin : digest_check
        digest_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_q.size() == 0)
                flag_mismatch("digest beat with none expected", m_tdata, '0);
            else
            begin
                want = digest_q.pop_front();
                if (m_tdata !== want.digest_word)
                    flag_mismatch("digest_word", m_tdata, want.digest_word);
                if (m_tlast !== want.last_word)
                    flag_mismatch("last_word", {31'b0, m_tlast}, {31'b0, want.last_word});
            end
            digests_seen++;
        end
    end

    // Ends the run if neither side completes a beat for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d digest words outstanding",
                     QUIET_LIMIT, digest_q.size());
            $display("sha256_block_hasher_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin : run
        int i;
        for (i = 0; i < 8; i++)
            chain_h[i] = SHA_IV[i];
        for (i = 0; i < 16; i++)
            sched_w[i] = '0;
        word_pos = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_words();
        test_chained_messages(90);
        test_output_stall();
        test_drain_pause();

        wait_for_digests();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Hashed %0d words in %0d messages (%0d blocks compressed).",
                 words_sent, messages_sent, blocks_hashed);
        $display("Checked %0d digest beats under random stalls and one long hold-off.",
                 digests_seen);
        if (error_count == 0)
            $display("sha256_block_hasher_test: clean");
        else
            $display("sha256_block_hasher_test: errors");
        $finish;
    end

endmodule
